@@ rtl/lcdc_pkg.sv @@
// Shared types and constants for the character LCD controller core.
`timescale 1ns / 1ps

package lcdc_pkg;

  // Word kinds on the input tuser
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned VIEW_W  = 6;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  // Screen geometry: two lines of 40 cells, the second starting at 64
  localparam int unsigned LINE1_LAST = 39;
  localparam int unsigned LINE2_BASE = 64;
  localparam int unsigned LINE2_LAST = 103;

  localparam logic [ADDR_W-1:0]  ADDR_LINE1_LAST = 7'd39;
  localparam logic [ADDR_W-1:0]  ADDR_LINE2_BASE = 7'd64;
  localparam logic [ADDR_W-1:0]  ADDR_LINE2_LAST = 7'd103;
  localparam logic [VIEW_W-1:0]  VIEW_LAST       = 6'd39;

  // Cursor glyph cell and its contents after reset
  localparam logic [ADDR_W-1:0]  CURSOR_CELL  = 7'd40;
  localparam logic [VALUE_W-1:0] CURSOR_GLYPH = 8'd95;

  // Character code offset applied on data writes
  localparam logic [VALUE_W-1:0] CHAR_OFFSET = 8'd32;

  // Entry mode after reset: increment, no display shift
  localparam logic [MODE_W-1:0] MODE_RESET = 2'b10;

  // Command from the sequencer to the datapath
  typedef struct packed {
    logic exec;   // execute the word on the input bus this cycle
  } ctrl_cmd_t;

endpackage

@@ rtl/lcdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lcdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lcdc_ctrl.sv @@
// Handshake sequencer: takes one word, then holds its result until taken.
`timescale 1ns / 1ps

module lcdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output lcdc_pkg::ctrl_cmd_t cmd
);

  import lcdc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state;
  logic state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_HOLD);
  assign cmd.exec = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/lcdc_datapath.sv @@
// Instruction decode, counters, flags and character store of the LCD core.
`timescale 1ns / 1ps

module lcdc_datapath #(
  parameter int unsigned STORE_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lcdc_pkg::ctrl_cmd_t                 cmd,
  input  logic [lcdc_pkg::OP_W-1:0]           op,
  input  logic [lcdc_pkg::VALUE_W-1:0]        value,
  input  logic [lcdc_pkg::ADDR_W-1:0]         read_addr,
  output logic [lcdc_pkg::VALUE_W-1:0]        read_data,
  output logic [lcdc_pkg::ADDR_W-1:0]         address_counter,
  output logic [lcdc_pkg::VIEW_W-1:0]         display_start,
  output logic                                display_on,
  output logic                                cursor_on,
  output logic                                blink_on,
  output logic [lcdc_pkg::MODE_W-1:0]         entry_mode,
  output logic                                glyph_ram_selected
);

  import lcdc_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  function automatic logic [ADDR_W-1:0] addr_up(input logic [ADDR_W-1:0] a);
    if (a >= ADDR_LINE2_LAST) return '0;
    if (a == ADDR_LINE1_LAST) return ADDR_LINE2_BASE;
    return a + 7'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_down(input logic [ADDR_W-1:0] a);
    if (a == '0) return ADDR_LINE2_LAST;
    if (a == ADDR_LINE2_BASE) return ADDR_LINE1_LAST;
    return a - 7'd1;
  endfunction

  function automatic logic [VIEW_W-1:0] view_up(input logic [VIEW_W-1:0] v);
    return (v >= VIEW_LAST) ? '0 : v + 6'd1;
  endfunction

  function automatic logic [VIEW_W-1:0] view_down(input logic [VIEW_W-1:0] v);
    return (v == '0 || v > VIEW_LAST) ? VIEW_LAST : v - 6'd1;
  endfunction

  // Architectural state
  logic [ADDR_W-1:0] addr_count, addr_count_next;
  logic [VIEW_W-1:0] view_start, view_start_next;
  logic [MODE_W-1:0] mode_bits, mode_bits_next;
  logic              disp_enable, disp_enable_next;
  logic              curs_enable, curs_enable_next;
  logic              blink_enable, blink_enable_next;
  logic              glyph_select, glyph_select_next;
  logic              clear_req;

  // Per-cell written marks; an unmarked cell reads as its reset contents
  logic [STORE_DEPTH-1:0] cell_valid;

  // Read result bookkeeping
  logic               rd_active;
  logic               rd_hit;
  logic [VALUE_W-1:0] rd_dflt;
  logic [VALUE_W-1:0] ram_rdata;

  logic ram_we;
  logic ram_re;
  logic write_in_range;
  logic read_in_range;

  assign write_in_range = (32'(addr_count) < STORE_DEPTH);
  assign read_in_range  = (32'(read_addr) < STORE_DEPTH);

  assign ram_we = cmd.exec && (op == OP_WRITE) && !glyph_select && write_in_range;
  assign ram_re = cmd.exec && (op == OP_READ) && read_in_range;

  always_comb begin
    addr_count_next   = addr_count;
    view_start_next   = view_start;
    mode_bits_next    = mode_bits;
    disp_enable_next  = disp_enable;
    curs_enable_next  = curs_enable;
    blink_enable_next = blink_enable;
    glyph_select_next = glyph_select;
    clear_req         = 1'b0;

    if (op == OP_CMD) begin
      // Decode by the leading one bit
      priority if (value[7]) begin
        addr_count_next   = value[6:0];
        glyph_select_next = 1'b0;
      end else if (value[6]) begin
        glyph_select_next = 1'b1;
      end else if (value[5]) begin
        // function set: nothing to do
      end else if (value[4]) begin
        if (value[3]) begin
          view_start_next = value[2] ? view_down(view_start) : view_up(view_start);
        end else begin
          addr_count_next = value[2] ? addr_up(addr_count) : addr_down(addr_count);
        end
      end else if (value[3]) begin
        blink_enable_next = value[0];
        curs_enable_next  = value[1];
        disp_enable_next  = value[2];
      end else if (value[2]) begin
        mode_bits_next = value[1:0];
      end else if (value[1]) begin
        addr_count_next = '0;
        view_start_next = '0;
      end else if (value[0]) begin
        addr_count_next = '0;
        view_start_next = '0;
        clear_req       = 1'b1;
      end else begin
        // zero byte: nothing to do
      end
    end else if (op == OP_WRITE && !glyph_select) begin
      if (mode_bits[1]) begin
        addr_count_next = addr_up(addr_count);
        if (mode_bits[0]) begin
          view_start_next = view_up(view_start);
        end
      end else begin
        addr_count_next = addr_down(addr_count);
        if (mode_bits[0]) begin
          view_start_next = view_down(view_start);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_count   <= '0;
      view_start   <= '0;
      mode_bits    <= MODE_RESET;
      disp_enable  <= 1'b1;
      curs_enable  <= 1'b0;
      blink_enable <= 1'b0;
      glyph_select <= 1'b0;
      cell_valid   <= '0;
      rd_active    <= 1'b0;
    end else if (cmd.exec) begin
      addr_count   <= addr_count_next;
      view_start   <= view_start_next;
      mode_bits    <= mode_bits_next;
      disp_enable  <= disp_enable_next;
      curs_enable  <= curs_enable_next;
      blink_enable <= blink_enable_next;
      glyph_select <= glyph_select_next;
      rd_active    <= ram_re;
      if (ram_we) begin
        cell_valid[addr_count[AW-1:0]] <= 1'b1;
      end
      if (clear_req) begin
        // Drop the written marks over both visible lines; the cursor cell stays
        for (int k = 0; k < STORE_DEPTH; k++) begin
          if (k <= LINE1_LAST || (k >= LINE2_BASE && k <= LINE2_LAST)) begin
            cell_valid[k] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_hit  <= cell_valid[read_addr[AW-1:0]];
      rd_dflt <= (read_addr == CURSOR_CELL) ? CURSOR_GLYPH : '0;
    end
  end

  lcdc_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_count[AW-1:0]),
    .wdata (value - CHAR_OFFSET),
    .re    (ram_re),
    .raddr (read_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign read_data          = !rd_active ? '0 : (rd_hit ? ram_rdata : rd_dflt);
  assign address_counter    = addr_count;
  assign display_start      = view_start;
  assign display_on         = disp_enable;
  assign cursor_on          = curs_enable;
  assign blink_on           = blink_enable;
  assign entry_mode         = mode_bits;
  assign glyph_ram_selected = glyph_select;

endmodule

@@ rtl/char_lcd_controller_core.sv @@
// Top level of the character LCD controller core: stream ports, sequencer and datapath.
// A word accepted at a clock edge shows its result word from the next cycle on.
// No new word is taken while a result waits: the sequencer holds s_tready low until
//   the master side takes it. Clear completes at the accept edge like any other word.
// Reset (rst, synchronous): counters and flags return to power-up values, every cell
//   reads zero except the cursor glyph cell, which reads 95; no clearing pass is needed.
`timescale 1ns / 1ps

module char_lcd_controller_core #(
  parameter int unsigned STORE_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  // Slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lcdc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] value, [14:8] read_addr
  input  logic [lcdc_pkg::OP_W-1:0]           s_tuser,   // [1:0] op
  // Master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] read_data, [14:8] address_counter, [20:15] display_start, [21] display_on,
  // [22] cursor_on, [23] blink_on, [25:24] entry_mode, [26] glyph_ram_selected
  output logic [lcdc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  import lcdc_pkg::*;

  ctrl_cmd_t cmd;

  logic [VALUE_W-1:0] read_data;
  logic [ADDR_W-1:0]  address_counter;
  logic [VIEW_W-1:0]  display_start;
  logic               display_on;
  logic               cursor_on;
  logic               blink_on;
  logic [MODE_W-1:0]  entry_mode;
  logic               glyph_ram_selected;

  // Sequencer: take a word when idle, hold the result until the sink takes it
  lcdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Datapath: executes the word on the accept edge; state registers then
  // stay put until the next accept, so they double as the output register
  lcdc_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .op                 (s_tuser),
    .value              (s_tdata[7:0]),
    .read_addr          (s_tdata[14:8]),
    .read_data          (read_data),
    .address_counter    (address_counter),
    .display_start      (display_start),
    .display_on         (display_on),
    .cursor_on          (cursor_on),
    .blink_on           (blink_on),
    .entry_mode         (entry_mode),
    .glyph_ram_selected (glyph_ram_selected)
  );

  // Pack the result word, first field in the lowest bits, zero fill on top
  assign m_tdata = {5'b0, glyph_ram_selected, entry_mode, blink_on, cursor_on,
                    display_on, display_start, address_counter, read_data};

endmodule
